/* rtl/cau_pkg.sv */
`default_nettype none
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int NUM_W     = PROD_W + 1;
  localparam int SHN_W     = PROD_W + FRAC_BITS;
  localparam int SAT_W     = NUM_W + 1;
  localparam int SR_W      = WORD_BITS + 3;
  localparam int N_CELLS   = WORD_BITS;

  typedef enum logic [2:0] {
    FN_ADD  = 3'd0,
    FN_SUB  = 3'd1,
    FN_MUL  = 3'd2,
    FN_DIV  = 3'd3,
    FN_CONJ = 3'd4,
    FN_MAG  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]                  func;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_re;
    logic signed [WORD_BITS-1:0] res_im;
    logic [1:0]                  status;
  } out_t;

  // state handed from cell to cell
  typedef struct packed {
    logic [2:0]           func;
    logic [PROD_W-1:0]    den;
    logic [PROD_W-1:0]    rem_re;
    logic [PROD_W-1:0]    rem_im;
    logic [WORD_BITS-1:0] nb_re;
    logic [WORD_BITS-1:0] nb_im;
    logic [WORD_BITS-1:0] q_re;
    logic [WORD_BITS-1:0] q_im;
    logic                 neg_re;
    logic                 neg_im;
    logic                 ovf_re;
    logic                 ovf_im;
    logic                 dz;
    logic [PROD_W-1:0]    sb;
    logic [SR_W-1:0]      srem;
    logic [WORD_BITS-1:0] root;
    logic [WORD_BITS-1:0] pre_re;
    logic [WORD_BITS-1:0] pre_im;
    logic                 pre_sat;
  } chain_t;

  // clamp to the signed word range, msb of the result flags a clamp
  function automatic logic [WORD_BITS:0] sat_word(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi_b;
    logic signed [SAT_W-1:0] lo_b;
    logic [WORD_BITS:0]      r;
    hi_b = (SAT_W'(1) <<< (WORD_BITS - 1)) - SAT_W'(1);
    lo_b = -hi_b - SAT_W'(1);
    if (v > hi_b) begin
      r = {1'b1, hi_b[WORD_BITS-1:0]};
    end else if (v < lo_b) begin
      r = {1'b1, lo_b[WORD_BITS-1:0]};
    end else begin
      r = {1'b0, v[WORD_BITS-1:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/cau_front.sv */
`default_nettype none
module cau_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  cau_pkg::in_t    in_data,
  output logic            out_vld,
  output cau_pkg::chain_t out_c
);
  import cau_pkg::*;

  // stage 1: products, plus the add, sub and conj results
  logic                        s1_vld_r;
  logic [2:0]                  s1_func_r;
  logic signed [PROD_W-1:0]    p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_xx_r, p_yy_r;
  logic signed [WORD_BITS:0]   s1_pre_re_r, s1_pre_im_r;
  logic signed [WORD_BITS-1:0] x, y;
  logic signed [WORD_BITS:0]   pre_re_nxt, pre_im_nxt;

  // stage 2: sums
  logic                     s2_vld_r;
  logic [2:0]               s2_func_r;
  logic signed [NUM_W-1:0]  num_re_r, num_im_r;
  logic [PROD_W-1:0]        den_r;
  logic [WORD_BITS-1:0]     s2_pre_re_r, s2_pre_im_r;
  logic                     s2_pre_sat_r;
  logic signed [NUM_W-1:0]  num_re_nxt, num_im_nxt;
  logic [PROD_W-1:0]        den_nxt;
  logic signed [NUM_W-1:0]  sh_re, sh_im;
  logic [WORD_BITS:0]       sw_re, sw_im;

  // stage 3: chain setup
  logic                     s3_vld_r;
  chain_t                   c_r;
  chain_t                   c_nxt;
  logic [PROD_W-1:0]        mag_re, mag_im;
  logic [SHN_W-1:0]         n_re, n_im;

  always_comb begin
    x = (in_data.func == FN_MAG) ? in_data.a_re : in_data.b_re;
    y = (in_data.func == FN_MAG) ? in_data.a_im : in_data.b_im;
    unique case (in_data.func)
      FN_ADD: begin
        pre_re_nxt = in_data.a_re + in_data.b_re;
        pre_im_nxt = in_data.a_im + in_data.b_im;
      end
      FN_SUB: begin
        pre_re_nxt = in_data.a_re - in_data.b_re;
        pre_im_nxt = in_data.a_im - in_data.b_im;
      end
      FN_CONJ: begin
        pre_re_nxt = in_data.a_re;
        pre_im_nxt = -in_data.a_im;
      end
      default: begin
        pre_re_nxt = '0;
        pre_im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
    end
    if (en) begin
      s1_func_r   <= in_data.func;
      p_rr_r      <= in_data.a_re * in_data.b_re;
      p_ii_r      <= in_data.a_im * in_data.b_im;
      p_ri_r      <= in_data.a_re * in_data.b_im;
      p_ir_r      <= in_data.a_im * in_data.b_re;
      p_xx_r      <= x * x;
      p_yy_r      <= y * y;
      s1_pre_re_r <= pre_re_nxt;
      s1_pre_im_r <= pre_im_nxt;
    end
  end

  always_comb begin
    if (s1_func_r == FN_MUL) begin
      num_re_nxt = p_rr_r - p_ii_r;
      num_im_nxt = p_ri_r + p_ir_r;
    end else begin
      num_re_nxt = p_rr_r + p_ii_r;
      num_im_nxt = p_ir_r - p_ri_r;
    end
    den_nxt = $unsigned(p_xx_r) + $unsigned(p_yy_r);
    sh_re   = num_re_nxt >>> FRAC_BITS;
    sh_im   = num_im_nxt >>> FRAC_BITS;
    if (s1_func_r == FN_MUL) begin
      sw_re = sat_word(SAT_W'(sh_re));
      sw_im = sat_word(SAT_W'(sh_im));
    end else begin
      sw_re = sat_word(SAT_W'(s1_pre_re_r));
      sw_im = sat_word(SAT_W'(s1_pre_im_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
    if (en) begin
      s2_func_r    <= s1_func_r;
      num_re_r     <= num_re_nxt;
      num_im_r     <= num_im_nxt;
      den_r        <= den_nxt;
      s2_pre_re_r  <= sw_re[WORD_BITS-1:0];
      s2_pre_im_r  <= sw_im[WORD_BITS-1:0];
      s2_pre_sat_r <= sw_re[WORD_BITS] | sw_im[WORD_BITS];
    end
  end

  always_comb begin
    mag_re = num_re_r[NUM_W-1] ? PROD_W'(-num_re_r) : PROD_W'(num_re_r);
    mag_im = num_im_r[NUM_W-1] ? PROD_W'(-num_im_r) : PROD_W'(num_im_r);
    n_re   = {mag_re, {FRAC_BITS{1'b0}}};
    n_im   = {mag_im, {FRAC_BITS{1'b0}}};
    c_nxt.func    = s2_func_r;
    c_nxt.den     = den_r;
    // upper part of the numerator seeds the remainder, quotient bit width stays one word
    c_nxt.rem_re  = PROD_W'(n_re[SHN_W-1:WORD_BITS]);
    c_nxt.rem_im  = PROD_W'(n_im[SHN_W-1:WORD_BITS]);
    c_nxt.nb_re   = n_re[WORD_BITS-1:0];
    c_nxt.nb_im   = n_im[WORD_BITS-1:0];
    c_nxt.q_re    = '0;
    c_nxt.q_im    = '0;
    c_nxt.neg_re  = num_re_r[NUM_W-1];
    c_nxt.neg_im  = num_im_r[NUM_W-1];
    c_nxt.ovf_re  = PROD_W'(n_re[SHN_W-1:WORD_BITS]) >= den_r;
    c_nxt.ovf_im  = PROD_W'(n_im[SHN_W-1:WORD_BITS]) >= den_r;
    c_nxt.dz      = (den_r == '0);
    c_nxt.sb      = den_r;
    c_nxt.srem    = '0;
    c_nxt.root    = '0;
    c_nxt.pre_re  = s2_pre_re_r;
    c_nxt.pre_im  = s2_pre_im_r;
    c_nxt.pre_sat = s2_pre_sat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign out_vld = s3_vld_r;
  assign out_c   = c_r;

endmodule
`default_nettype wire

/* rtl/cau_cell.sv */
`default_nettype none
module cau_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  cau_pkg::chain_t in_c,
  output logic            out_vld,
  output cau_pkg::chain_t out_c
);
  import cau_pkg::*;

  logic              vld_r;
  chain_t            c_r;
  chain_t            c_nxt;
  logic [PROD_W-1:0] r_re, r_im;
  logic              ge_re, ge_im;
  logic [SR_W-1:0]   t, trial;
  logic              ge_s;

  always_comb begin
    c_nxt = in_c;
    // one restoring divide step per lane
    r_re  = {in_c.rem_re[PROD_W-2:0], in_c.nb_re[WORD_BITS-1]};
    r_im  = {in_c.rem_im[PROD_W-2:0], in_c.nb_im[WORD_BITS-1]};
    ge_re = r_re >= in_c.den;
    ge_im = r_im >= in_c.den;
    c_nxt.rem_re = ge_re ? r_re - in_c.den : r_re;
    c_nxt.rem_im = ge_im ? r_im - in_c.den : r_im;
    c_nxt.nb_re  = {in_c.nb_re[WORD_BITS-2:0], 1'b0};
    c_nxt.nb_im  = {in_c.nb_im[WORD_BITS-2:0], 1'b0};
    c_nxt.q_re   = {in_c.q_re[WORD_BITS-2:0], ge_re};
    c_nxt.q_im   = {in_c.q_im[WORD_BITS-2:0], ge_im};
    // one digit of the square root, two radicand bits in
    t     = {in_c.srem[SR_W-3:0], in_c.sb[PROD_W-1:PROD_W-2]};
    trial = SR_W'({in_c.root, 2'b01});
    ge_s  = t >= trial;
    c_nxt.srem = ge_s ? t - trial : t;
    c_nxt.root = {in_c.root[WORD_BITS-2:0], ge_s};
    c_nxt.sb   = {in_c.sb[PROD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_c   = c_r;

endmodule
`default_nettype wire

/* rtl/complex_arithmetic_unit_top.sv */
// a request passes 3 front stages, 32 cells and the output register on its way to a result
// throughput: one request per cycle while not stalled; each cell retires one quotient bit and one root digit
// the whole pipeline holds while the output register is full and stalled
// reset (rst_n low, synchronous) clears only the stage valid bits
`default_nettype none
module complex_arithmetic_unit_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cau_pkg::out_t out_data
);
  import cau_pkg::*;

  logic   en;
  logic   c_vld [N_CELLS+1];
  chain_t c_arr [N_CELLS+1];
  chain_t c;
  out_t   res_nxt;
  out_t   out_r;
  logic   out_vld_r;
  logic [WORD_BITS:0] sw_re, sw_im;

  function automatic logic signed [SAT_W-1:0] div_val(input logic [WORD_BITS-1:0] q,
                                                      input logic neg, input logic ovf);
    logic signed [WORD_BITS+1:0] e;
    e = ovf ? {2'b01, {WORD_BITS{1'b0}}} : {2'b00, q};
    if (neg) begin
      e = -e;
    end
    return SAT_W'(e);
  endfunction

  // root is below 2^WORD_BITS, so only the top bit can overflow the signed range
  function automatic logic [WORD_BITS-1:0] sw_mag(input logic [WORD_BITS-1:0] r);
    logic [WORD_BITS:0] s;
    s = sat_word(SAT_W'({1'b0, r}));
    return s[WORD_BITS-1:0];
  endfunction

  assign en       = !out_vld_r || !out_stall;
  assign in_stall = !en;

  cau_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .in_data (in_data),
    .out_vld (c_vld[0]),
    .out_c   (c_arr[0])
  );

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    cau_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (c_vld[i]),
      .in_c    (c_arr[i]),
      .out_vld (c_vld[i+1]),
      .out_c   (c_arr[i+1])
    );
  end

  assign c = c_arr[N_CELLS];

  always_comb begin
    sw_re   = sat_word(div_val(c.q_re, c.neg_re, c.ovf_re));
    sw_im   = sat_word(div_val(c.q_im, c.neg_im, c.ovf_im));
    res_nxt = '0;
    unique case (c.func) inside
      FN_ADD, FN_SUB, FN_MUL, FN_CONJ: begin
        res_nxt.res_re = c.pre_re;
        res_nxt.res_im = c.pre_im;
        res_nxt.status = c.pre_sat ? ST_SAT : ST_OK;
      end
      FN_DIV: begin
        if (c.dz) begin
          res_nxt.status = ST_DIVZ;
        end else begin
          res_nxt.res_re = sw_re[WORD_BITS-1:0];
          res_nxt.res_im = sw_im[WORD_BITS-1:0];
          res_nxt.status = (sw_re[WORD_BITS] | sw_im[WORD_BITS]) ? ST_SAT : ST_OK;
        end
      end
      FN_MAG: begin
        res_nxt.res_re = sw_mag(c.root);
        res_nxt.status = c.root[WORD_BITS-1] ? ST_SAT : ST_OK;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= c_vld[N_CELLS];
    end
    if (en) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  localparam logic signed [WORD_BITS-1:0] MAXW = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] MINW = {1'b1, {(WORD_BITS-1){1'b0}}};

  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_DIVZ |-> out_data.res_re == '0 && out_data.res_im == '0)
    else $error("divide by zero result not cleared");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_SAT |->
      (out_data.res_re == MAXW || out_data.res_re == MINW ||
       out_data.res_im == MAXW || out_data.res_im == MINW))
    else $error("saturation flagged without a clamped part");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped while stalled");

endmodule
`default_nettype wire
